// ===== hdl/irdc_pkg.sv =====
// Shared types, constants and helpers of the integer radix digit converter.
// No dependencies; every other file of the block but irdc_ram imports this package.
package irdc_pkg;

    localparam int MAG_WIDTH       = 64;
    localparam int CFG_WIDTH       = 7;
    localparam int CFG_INDEX_WIDTH = 2;
    localparam int DIGIT_WIDTH     = 6;
    localparam int CHAR_WIDTH      = 7;
    localparam int DEF_MAX_DIGITS  = 64;
    localparam int DEF_VALUE_WIDTH = 64;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        REG_RADIX      = 2'd0,
        REG_UPPER_CASE = 2'd1,
        REG_MIN_DIGITS = 2'd2
    } cfg_reg_t;

    localparam logic [DIGIT_WIDTH-1:0] RADIX_RESET      = 6'd10;
    localparam logic [DIGIT_WIDTH-1:0] RADIX_MIN        = 6'd2;
    localparam logic [DIGIT_WIDTH-1:0] RADIX_MAX        = 6'd36;
    localparam logic [CFG_WIDTH-1:0]   MIN_DIGITS_RESET = 7'd1;

    localparam logic [CHAR_WIDTH-1:0]  CHAR_ZERO    = 7'h30;
    localparam logic [CHAR_WIDTH-1:0]  CHAR_UPPER_A = 7'h41;
    localparam logic [CHAR_WIDTH-1:0]  CHAR_LOWER_A = 7'h61;
    localparam logic [DIGIT_WIDTH-1:0] DEC_BASE     = 6'd10;

    typedef struct packed {
        logic load;
        logic step;
        logic commit;
        logic begin_emit;
        logic fetch;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic value_zero;
        logic count_full;
        logic bit_done;
        logic total_zero;
        logic emit_last;
        logic out_free;
    } sts_t;

    function automatic logic [CHAR_WIDTH-1:0] digit_char(
        input logic [DIGIT_WIDTH-1:0] d,
        input logic                   upper
    );
        logic [CHAR_WIDTH-1:0] d7;
        d7 = {1'b0, d};
        if (d < DEC_BASE)
            return CHAR_ZERO + d7;
        else if (upper)
            return CHAR_UPPER_A + d7 - {1'b0, DEC_BASE};
        else
            return CHAR_LOWER_A + d7 - {1'b0, DEC_BASE};
    endfunction

endpackage

// ===== hdl/irdc_if.sv =====
// Valid/ready channel interfaces: magnitude input and character output.
// Depends on irdc_pkg for field widths.
interface irdc_in_if;
    import irdc_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [MAG_WIDTH-1:0] magnitude;
    logic                 negative;

    modport source (output valid, output magnitude, output negative, input ready);
    modport sink   (input valid, input magnitude, input negative, output ready);
endinterface

interface irdc_out_if;
    import irdc_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CHAR_WIDTH-1:0] character;
    logic                  sign_negative;
    logic                  last_digit;

    modport source (output valid, output character, output sign_negative,
                    output last_digit, input ready);
    modport sink   (input valid, input character, input sign_negative,
                    input last_digit, output ready);
endinterface

// ===== hdl/irdc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module irdc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hdl/irdc_ctrl.sv =====
// Sequencer of the converter: load, divide digit by digit, then emit.
// Depends on irdc_pkg for the command and status structs.
module irdc_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  irdc_pkg::sts_t  sts,
    output irdc_pkg::cmd_t  cmd
);
    import irdc_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_CHECK = 6'b000010,
        S_DIV   = 6'b000100,
        S_STORE = 6'b001000,
        S_FETCH = 6'b010000,
        S_EMIT  = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        in_ready   = (state_reg == S_IDLE);
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (sts.value_zero || sts.count_full)
                begin
                    cmd.begin_emit = 1'b1;
                    state_next     = sts.total_zero ? S_IDLE : S_FETCH;
                end
                else
                begin
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                cmd.step = 1'b1;
                if (sts.bit_done)
                begin
                    state_next = S_STORE;
                end
            end
            S_STORE:
            begin
                cmd.commit = 1'b1;
                state_next = S_CHECK;
            end
            S_FETCH:
            begin
                cmd.fetch  = 1'b1;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = sts.emit_last ? S_IDLE : S_FETCH;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== hdl/irdc_dp.sv =====
// Datapath: configuration registers, shift-subtract divider, digit store
// and output register. Depends on irdc_pkg and irdc_ram.
module irdc_dp #(
    parameter int MAX_DIGITS  = irdc_pkg::DEF_MAX_DIGITS,
    parameter int VALUE_WIDTH = irdc_pkg::DEF_VALUE_WIDTH
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [irdc_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [irdc_pkg::CFG_WIDTH-1:0]       cfg_data,
    input  logic [irdc_pkg::MAG_WIDTH-1:0]       magnitude,
    input  logic                                 negative,
    input  irdc_pkg::cmd_t                       cmd,
    output irdc_pkg::sts_t                       sts,
    input  logic                                 out_ready,
    output logic                                 out_valid,
    output logic [irdc_pkg::CHAR_WIDTH-1:0]      character,
    output logic                                 sign_negative,
    output logic                                 last_digit
);
    import irdc_pkg::*;

    localparam int CW = $clog2(MAX_DIGITS + 1);
    localparam int IW = $clog2(MAX_DIGITS);
    localparam int BW = $clog2(VALUE_WIDTH);
    localparam logic [CW-1:0]        MAX_CNT  = CW'(MAX_DIGITS);
    localparam logic [CFG_WIDTH-1:0] MAX_CFG  = CFG_WIDTH'(MAX_DIGITS);
    localparam logic [BW-1:0]        LAST_BIT = BW'(VALUE_WIDTH - 1);

    logic [DIGIT_WIDTH-1:0] radix_reg;
    logic                   upper_reg;
    logic [CFG_WIDTH-1:0]   min_reg;

    logic [VALUE_WIDTH-1:0] value_reg;
    logic [DIGIT_WIDTH-1:0] rem_reg;
    logic [BW-1:0]          bit_cnt_reg;
    logic [CW-1:0]          count_reg;
    logic [CW-1:0]          total_reg;
    logic [CW-1:0]          pos_reg;
    logic                   neg_reg;
    logic                   pad_reg;
    logic                   out_valid_reg;
    logic [CHAR_WIDTH-1:0]  char_reg;
    logic                   sign_reg;
    logic                   last_reg;

    logic [DIGIT_WIDTH-1:0] base;
    logic [CW-1:0]          minimum;
    logic [DIGIT_WIDTH:0]   rem_shift;
    logic [DIGIT_WIDTH:0]   rem_diff;
    logic                   rem_ge;
    logic [DIGIT_WIDTH-1:0] rem_next;
    logic [CW-1:0]          total_next;
    logic [CW-1:0]          rd_offset;
    logic [DIGIT_WIDTH-1:0] rd_digit;
    logic [CHAR_WIDTH-1:0]  char_next;

    always_comb
    begin
        if (radix_reg < RADIX_MIN)
            base = RADIX_MIN;
        else if (radix_reg > RADIX_MAX)
            base = RADIX_MAX;
        else
            base = radix_reg;
        minimum    = (min_reg > MAX_CFG) ? MAX_CNT : min_reg[CW-1:0];
        rem_shift  = {rem_reg, value_reg[VALUE_WIDTH-1]};
        rem_diff   = rem_shift - {1'b0, base};
        rem_ge     = (rem_shift >= {1'b0, base});
        rem_next   = rem_ge ? rem_diff[DIGIT_WIDTH-1:0] : rem_shift[DIGIT_WIDTH-1:0];
        total_next = (count_reg > minimum) ? count_reg : minimum;
        rd_offset  = total_reg - CW'(1) - pos_reg;
        char_next  = pad_reg ? CHAR_ZERO : digit_char(rd_digit, upper_reg);
    end

    always_comb
    begin
        sts.value_zero = (value_reg == '0);
        sts.count_full = (count_reg == MAX_CNT);
        sts.bit_done   = (bit_cnt_reg == LAST_BIT);
        sts.total_zero = (count_reg == '0) && (minimum == '0);
        sts.emit_last  = (pos_reg == total_reg - CW'(1));
        sts.out_free   = !out_valid_reg || out_ready;
    end

    irdc_ram #(
        .WIDTH (DIGIT_WIDTH),
        .DEPTH (MAX_DIGITS)
    ) u_digit_ram (
        .clk     (clk),
        .wr_en   (cmd.commit),
        .wr_addr (count_reg[IW-1:0]),
        .wr_data (rem_reg),
        .rd_addr (rd_offset[IW-1:0]),
        .rd_data (rd_digit)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg     <= RADIX_RESET;
            upper_reg     <= 1'b0;
            min_reg       <= MIN_DIGITS_RESET;
            bit_cnt_reg   <= '0;
            count_reg     <= '0;
            total_reg     <= '0;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_RADIX:      radix_reg <= cfg_data[DIGIT_WIDTH-1:0];
                    REG_UPPER_CASE: upper_reg <= cfg_data[0];
                    REG_MIN_DIGITS: min_reg   <= cfg_data;
                    default:        ;
                endcase
            end
            if (cmd.load)
            begin
                bit_cnt_reg <= '0;
                count_reg   <= '0;
            end
            else if (cmd.step)
            begin
                bit_cnt_reg <= bit_cnt_reg + BW'(1);
            end
            else if (cmd.commit)
            begin
                bit_cnt_reg <= '0;
                count_reg   <= count_reg + CW'(1);
            end
            if (cmd.begin_emit)
            begin
                total_reg <= total_next;
                pos_reg   <= '0;
            end
            else if (cmd.emit)
            begin
                pos_reg <= pos_reg + CW'(1);
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            value_reg <= magnitude[VALUE_WIDTH-1:0];
            rem_reg   <= '0;
            neg_reg   <= negative;
        end
        else if (cmd.step)
        begin
            value_reg <= {value_reg[VALUE_WIDTH-2:0], rem_ge};
            rem_reg   <= rem_next;
        end
        else if (cmd.commit)
        begin
            rem_reg <= '0;
        end
        if (cmd.fetch)
        begin
            pad_reg <= (rd_offset >= count_reg);
        end
        if (cmd.emit)
        begin
            char_reg <= char_next;
            sign_reg <= neg_reg;
            last_reg <= sts.emit_last;
        end
    end

    assign out_valid     = out_valid_reg;
    assign character     = char_reg;
    assign sign_negative = sign_reg;
    assign last_digit    = last_reg;

endmodule

// ===== hdl/integer_radix_digit_converter.sv =====
// Top level of the integer radix digit converter: ports, sequencer and datapath.
// Depends on irdc_pkg, irdc_if, irdc_ctrl and irdc_dp.
//
//   channel  | dir | beat contents
//   ---------+-----+----------------------------------------------
//   in_ch    | in  | magnitude[63:0], negative
//   out_ch   | out | character[6:0], sign_negative, last_digit
//   cfg      | in  | cfg_we, cfg_index[1:0], cfg_data[6:0]
//
// Each digit is one bit-serial shift-subtract division of the value by the
// radix; each character is one digit-store read and one output-register load.
// Reset clears control state and the configuration registers; the digit store is not cleared.
// A stalled output beat holds the sequencer in its emit step.
module integer_radix_digit_converter #(
    parameter int MAX_DIGITS  = irdc_pkg::DEF_MAX_DIGITS,
    parameter int VALUE_WIDTH = irdc_pkg::DEF_VALUE_WIDTH
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [irdc_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [irdc_pkg::CFG_WIDTH-1:0]       cfg_data,
    irdc_in_if.sink                              in_ch,
    irdc_out_if.source                           out_ch
);
    import irdc_pkg::*;

    cmd_t cmd;
    sts_t sts;

    irdc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    irdc_dp #(
        .MAX_DIGITS  (MAX_DIGITS),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .magnitude     (in_ch.magnitude),
        .negative      (in_ch.negative),
        .cmd           (cmd),
        .sts           (sts),
        .out_ready     (out_ch.ready),
        .out_valid     (out_ch.valid),
        .character     (out_ch.character),
        .sign_negative (out_ch.sign_negative),
        .last_digit    (out_ch.last_digit)
    );

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.valid && in_ch.ready |=> !in_ch.ready)
        else $error("input taken again straight after a beat");

    a_emit_into_free_reg: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> sts.out_free)
        else $error("output register overwritten while held");

    a_char_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> (out_ch.character >= CHAR_ZERO && out_ch.character <= 7'd122))
        else $error("character outside digit range");

    a_divide_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step |-> !in_ch.ready && !cmd.emit)
        else $error("division step while idle or emitting");
`endif

endmodule

// ===== tb/tb_top.sv =====
// Testbench for integer_radix_digit_converter: predicts the ASCII digit beats of each
// number in step with the live configuration and checks every output beat in order.
// Depends on irdc_pkg, irdc_if and the converter RTL.
`timescale 1ns / 100ps

module tb_top;
    import irdc_pkg::*;

    localparam int  CLK_LIMIT     = 20_000_000;
    localparam int  SETTLE_CYCLES = 64;
    localparam int  TAIL_CYCLES   = 200;
    localparam int  PRINT_CAP     = 50;

    typedef struct packed {
        logic [CHAR_WIDTH-1:0] character;
        logic                  sign_negative;
        logic                  last_digit;
    } char_beat_t;

    logic                       clk;
    logic                       rst_n;
    logic                       cfg_we;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index;
    logic [CFG_WIDTH-1:0]       cfg_data;

    irdc_in_if  in_ch ();
    irdc_out_if out_ch ();

    integer_radix_digit_converter DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    logic [DIGIT_WIDTH-1:0] cur_radix;
    logic                   cur_upper;
    logic [CFG_WIDTH-1:0]   cur_min_digits;

    char_beat_t pending_chars[$];
    int         mismatches;
    int         cycle_count;
    bit         back_to_back;

    initial
    begin
        clk = 1'b0;
    end

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CLK_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        if (mismatches < PRINT_CAP)
            $display("[%0t] mismatch: %s", $time, msg);
        mismatches++;
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return 0;
        else if (r < 88)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 45);
    endfunction

    function automatic logic [CHAR_WIDTH-1:0] digit_to_ascii(input logic [DIGIT_WIDTH-1:0] d);
        logic [CHAR_WIDTH-1:0] d7;
        d7 = {1'b0, d};
        if (d7 < 7'd10)
            return CHAR_ZERO + d7;
        else if (cur_upper)
            return CHAR_UPPER_A + d7 - 7'd10;
        else
            return CHAR_LOWER_A + d7 - 7'd10;
    endfunction

    function automatic void predict_number(input logic [MAG_WIDTH-1:0] mag, input logic neg);
        logic [MAG_WIDTH-1:0]   rest;
        logic [DIGIT_WIDTH-1:0] base;
        logic [DIGIT_WIDTH-1:0] digs [DEF_MAX_DIGITS];
        int                     minimum;
        int                     count;
        int                     total;
        int                     pad;
        char_beat_t             beat;
        base = cur_radix;
        if (base < RADIX_MIN)
            base = RADIX_MIN;
        if (base > RADIX_MAX)
            base = RADIX_MAX;
        minimum = (cur_min_digits > DEF_MAX_DIGITS) ? DEF_MAX_DIGITS : int'(cur_min_digits);
        rest = mag;
        count = 0;
        while (rest != 0 && count < DEF_MAX_DIGITS)
        begin
            digs[count] = DIGIT_WIDTH'(rest % base);
            rest = rest / base;
            count++;
        end
        total = (count > minimum) ? count : minimum;
        pad = total - count;
        for (int k = 0; k < total; k++)
        begin
            if (k < pad)
                beat.character = CHAR_ZERO;
            else
                beat.character = digit_to_ascii(digs[count - 1 - (k - pad)]);
            beat.sign_negative = neg;
            beat.last_digit    = (k + 1 == total);
            pending_chars.push_back(beat);
        end
    endfunction

    always @(posedge clk)
    begin
        char_beat_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (pending_chars.size() == 0)
                report_mismatch($sformatf("unexpected beat char=%0h", out_ch.character));
            else
            begin
                want = pending_chars.pop_front();
                if (out_ch.character !== want.character)
                    report_mismatch($sformatf("character got %0h want %0h",
                                              out_ch.character, want.character));
                if (out_ch.sign_negative !== want.sign_negative)
                    report_mismatch($sformatf("sign_negative got %0b want %0b",
                                              out_ch.sign_negative, want.sign_negative));
                if (out_ch.last_digit !== want.last_digit)
                    report_mismatch($sformatf("last_digit got %0b want %0b",
                                              out_ch.last_digit, want.last_digit));
            end
        end
    end

    initial
    begin
        int run;
        int gap;
        out_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            run = ($urandom_range(0, 9) == 0) ? $urandom_range(150, 500) : $urandom_range(1, 40);
            repeat (run) @(negedge clk) out_ch.ready <= 1'b1;
            gap = pick_gap();
            repeat (gap) @(negedge clk) out_ch.ready <= 1'b0;
        end
    end

    task automatic send_number(input logic [MAG_WIDTH-1:0] mag, input logic neg);
        int gap;
        gap = back_to_back ? 0 : pick_gap();
        repeat (gap) @(negedge clk) in_ch.valid <= 1'b0;
        @(negedge clk);
        in_ch.valid     <= 1'b1;
        in_ch.magnitude <= mag;
        in_ch.negative  <= neg;
        predict_number(mag, neg);
        do
            @(posedge clk);
        while (in_ch.ready !== 1'b1);
    endtask

    task automatic wait_drained();
        @(negedge clk) in_ch.valid <= 1'b0;
        while (pending_chars.size() != 0)
            @(posedge clk);
    endtask

    // drain fully before touching the registers
    task automatic settle();
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_WIDTH-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        case (idx)
            REG_RADIX:      cur_radix = data[DIGIT_WIDTH-1:0];
            REG_UPPER_CASE: cur_upper = data[0];
            REG_MIN_DIGITS: cur_min_digits = data;
            default: ;
        endcase
        @(negedge clk) cfg_we <= 1'b0;
    endtask

    task automatic configure(input logic [CFG_WIDTH-1:0] radix_val, input logic upper_val,
                             input logic [CFG_WIDTH-1:0] min_val);
        settle();
        write_reg(REG_RADIX, radix_val);
        write_reg(REG_UPPER_CASE, {6'd0, upper_val});
        write_reg(REG_MIN_DIGITS, min_val);
    endtask

    function automatic logic [MAG_WIDTH-1:0] rand_magnitude();
        logic [MAG_WIDTH-1:0] v;
        int                   w;
        v = {$urandom(), $urandom()};
        case ($urandom_range(0, 19))
            0:       return '0;
            1:       return '1;
            2, 3:    w = $urandom_range(0, 8);
            default: w = $urandom_range(0, 64);
        endcase
        if (w < MAG_WIDTH)
            v &= (64'd1 << w) - 64'd1;
        return v;
    endfunction

    task automatic test_reset_defaults();
        send_number(64'd0, 1'b0);
        send_number(64'd12345, 1'b1);
        send_number('1, 1'b1);
        send_number(64'd1, 1'b0);
    endtask

    task automatic test_radix_extremes();
        configure(7'd2, 1'b0, 7'd1);
        send_number('1, 1'b0);
        send_number(64'h8000_0000_0000_0000, 1'b1);
        configure(7'd36, 1'b1, 7'd1);
        send_number('1, 1'b1);
        send_number(64'd35, 1'b0);
        configure(7'd36, 1'b0, 7'd1);
        send_number(64'd35, 1'b1);
    endtask

    task automatic test_zero_and_padding();
        configure(7'd10, 1'b0, 7'd0);
        send_number(64'd0, 1'b1);
        send_number(64'd7, 1'b0);
        configure(7'd16, 1'b1, 7'd64);
        send_number(64'd0, 1'b0);
        configure(7'd16, 1'b0, 7'd127);
        send_number(64'd0, 1'b1);
        configure(7'd16, 1'b0, 7'd65);
        send_number(64'd1, 1'b0);
    endtask

    task automatic test_radix_clamp();
        configure(7'd0, 1'b0, 7'd1);
        send_number(64'd5, 1'b0);
        configure(7'd1, 1'b0, 7'd1);
        send_number(64'd5, 1'b1);
        configure(7'd37, 1'b1, 7'd1);
        send_number(64'd35, 1'b0);
        configure(7'd127, 1'b0, 7'd3);
        send_number(64'd1295, 1'b1);
    endtask

    task automatic test_random_numbers();
        logic [CFG_WIDTH-1:0] radix_val;
        logic [CFG_WIDTH-1:0] min_val;
        for (int phase = 0; phase < 10; phase++)
        begin
            case (phase)
                0: begin radix_val = 7'd2;  min_val = 7'd0;  end
                1: begin radix_val = 7'd36; min_val = 7'd64; end
                2: begin radix_val = 7'd10; min_val = 7'd0;  end
                3: begin radix_val = 7'($urandom_range(0, 127)); min_val = 7'($urandom_range(65, 127)); end
                default:
                begin
                    radix_val = 7'($urandom_range(2, 36));
                    min_val   = 7'($urandom_range(0, 24));
                end
            endcase
            configure(radix_val, 1'($urandom()), min_val);
            back_to_back = (phase == 2);
            for (int i = 0; i < 40; i++)
            begin
                // hold off the sender until every beat so far has come back
                if (phase == 5 && i == 20)
                    wait_drained();
                send_number(rand_magnitude(), 1'($urandom()));
            end
            back_to_back = 1'b0;
        end
    endtask

    initial
    begin
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = REG_RADIX;
        cfg_data        = '0;
        in_ch.valid     = 1'b0;
        in_ch.magnitude = '0;
        in_ch.negative  = 1'b0;
        cur_radix       = RADIX_RESET;
        cur_upper       = 1'b0;
        cur_min_digits  = MIN_DIGITS_RESET;
        mismatches      = 0;
        cycle_count     = 0;
        back_to_back    = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk) rst_n <= 1'b1;

        test_reset_defaults();
        test_radix_extremes();
        test_zero_and_padding();
        test_radix_clamp();
        test_random_numbers();

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== integer_radix_digit_converter.f =====
hdl/irdc_pkg.sv
hdl/irdc_if.sv
hdl/irdc_ram.sv
hdl/irdc_ctrl.sv
hdl/irdc_dp.sv
hdl/integer_radix_digit_converter.sv
tb/tb_top.sv
